### rtl/lz4bd_pkg.sv
// lz4bd_pkg: shared types and constants of the LZ4 block decoder.
// Used by lz4_block_decoder; depends on nothing.
`timescale 1ns / 1ps
package lz4bd_pkg;

  localparam int unsigned LenW  = 21;
  localparam int unsigned ReadW = 22;

  typedef enum logic [1:0] {
    OP_START = 2'd0,
    OP_BYTE  = 2'd1,
    OP_DRAIN = 2'd2,
    OP_RSVD  = 2'd3
  } opcode_e;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_LIT_END  = 3'd1,
    ST_MATCH_END = 3'd2,
    ST_BAD_OFF  = 3'd3,
    ST_UNEXPECT = 3'd4
  } status_e;

  // Result word fields, from the highest bit down.
  typedef struct packed {
    logic [ReadW-1:0] bytes_read;
    logic [2:0]       status;
    logic             block_end;
    logic             want_byte;
    logic             out_valid;
    logic [7:0]       out_byte;
  } result_t;

endpackage

### rtl/lz4_block_decoder.sv
// lz4_block_decoder: byte-serial LZ4 block decoder, top level.
// Depends on lz4bd_pkg and lz4bd_history.
`timescale 1ns / 1ps
//
//   channel   dir  data
//   s_axis    in   tdata: opcode[1:0], data_byte[9:2], block_size[30:10]
//   m_axis    out  tdata: out_byte, out_valid, want_byte, block_end,
//                         status, bytes_read
//
// Every word is decoded combinationally as it is accepted; the next word can be
// taken in the next cycle while a result slot is free. A drain word for a match
// copies a byte from the history memory. The memory is read ahead: the read
// address for the next drain is computed from the next value of the output count,
// and a byte written in the same cycle as it is read is forwarded (offset of one).
// Each result goes through a two-entry skid stage, so the input is ready
// whenever a result slot is free. Reset clears all control state; the
// history memory is not cleared, since every read falls within bytes
// already written in the current block.
module lz4_block_decoder #(
  parameter int unsigned HISTORY_DEPTH   = 65536,
  parameter int unsigned MAX_BLOCK_BYTES = 1048576
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // opcode, data_byte, block_size
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata    // out_byte, out_valid, want_byte,
                                      // block_end, status, bytes_read
);

  localparam int unsigned AddrW = $clog2(HISTORY_DEPTH);
  localparam int unsigned LenW  = lz4bd_pkg::LenW;
  localparam int unsigned ReadW = lz4bd_pkg::ReadW;
  localparam logic [LenW-1:0]  LenCap  = {LenW{1'b1}};
  localparam logic [ReadW-1:0] ReadCap = {ReadW{1'b1}};
  localparam logic [LenW:0]    MaxBlk  = (MAX_BLOCK_BYTES > 2097151) ?
                                         (LenW+1)'(2097151) : (LenW+1)'(MAX_BLOCK_BYTES);
  localparam logic [LenW+1:0]  HistD   = (LenW+2)'(HISTORY_DEPTH);

  typedef enum logic [2:0] {
    PH_IDLE, PH_TOKEN, PH_LITEXT, PH_LIT, PH_OFFLO, PH_OFFHI, PH_MATEXT, PH_DRAIN
  } phase_e;

  phase_e          phase_q, phase_d;
  logic [LenW-1:0] prod_q, prod_d, tgt_q, tgt_d, lit_q, lit_d, mat_q, mat_d;
  logic [15:0]     off_q, off_d;
  logic [3:0]      tlow_q, tlow_d;
  logic [ReadW-1:0] cons_q, cons_d;

  // Input fields.
  lz4bd_pkg::opcode_e op;
  logic [7:0]      b;
  logic [LenW-1:0] size;
  assign op   = lz4bd_pkg::opcode_e'(s_axis_tdata[1:0]);
  assign b    = s_axis_tdata[9:2];
  assign size = s_axis_tdata[30:10];

  // Skid stage: two result slots.
  lz4bd_pkg::result_t slot_q [2];
  logic [1:0] cnt_q;
  logic       rd_q;
  logic       acc, pop;
  lz4bd_pkg::result_t res;

  assign s_axis_tready = (cnt_q != 2'd2);
  assign acc = s_axis_tvalid && s_axis_tready;
  assign m_axis_tvalid = (cnt_q != 2'd0);
  assign pop = m_axis_tvalid && m_axis_tready;
  assign m_axis_tdata = 40'(slot_q[rd_q]);

  // History memory with forwarding of the last written byte.
  logic             we;
  logic [7:0]       wdata;
  logic [AddrW-1:0] raddr;
  logic [7:0]       rdata, mem_rd;
  logic             fwd_q;
  logic [7:0]       fwd_byte_q;

  lz4bd_history #(.AddrW(AddrW)) u_hist (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(prod_q[AddrW-1:0]),
    .wdata_i(wdata),
    .raddr_i(raddr),
    .rdata_o(mem_rd)
  );
  assign rdata = fwd_q ? fwd_byte_q : mem_rd;

  // Sums used by the end checks.
  logic [LenW+1:0] tot_lit, tot_mat;
  logic [LenW-1:0] lit_new, mat_new, mat4;

  always_comb begin
    phase_d = phase_q;
    prod_d  = prod_q;
    tgt_d   = tgt_q;
    lit_d   = lit_q;
    mat_d   = mat_q;
    off_d   = off_q;
    tlow_d  = tlow_q;
    cons_d  = cons_q;
    we      = 1'b0;
    wdata   = b;
    res     = '0;
    lit_new = lit_q;
    mat_new = mat_q;
    tot_lit = '0;
    tot_mat = '0;
    mat4    = '0;

    if (acc) begin
      if (op == lz4bd_pkg::OP_START) begin
        tgt_d   = ({1'b0, size} > MaxBlk) ? MaxBlk[LenW-1:0] : size;
        prod_d  = '0;
        cons_d  = '0;
        lit_d   = '0;
        mat_d   = '0;
        off_d   = '0;
        tlow_d  = '0;
        phase_d = PH_TOKEN;
      end else if (op == lz4bd_pkg::OP_BYTE && phase_q != PH_IDLE &&
                   phase_q != PH_DRAIN) begin
        if (cons_q != ReadCap) cons_d = cons_q + 1'b1;
        case (phase_q)
          PH_TOKEN, PH_LITEXT: begin
            if (phase_q == PH_TOKEN) begin
              tlow_d  = b[3:0];
              lit_new = LenW'(b[7:4]);
            end else begin
              lit_new = ((LenW+1)'(lit_q) + (LenW+1)'(b) > (LenW+1)'(LenCap)) ?
                        LenCap : lit_q + LenW'(b);
            end
            lit_d = lit_new;
            if ((phase_q == PH_TOKEN && b[7:4] == 4'hF) ||
                (phase_q == PH_LITEXT && b == 8'hFF)) begin
              phase_d = PH_LITEXT;
            end else begin
              tot_lit = (LenW+2)'(prod_q) + (LenW+2)'(lit_new);
              if (tot_lit + (LenW+2)'(8) > (LenW+2)'(tgt_q)) begin
                if (tot_lit != (LenW+2)'(tgt_q)) begin
                  res.block_end = 1'b1;
                  res.status = lz4bd_pkg::ST_LIT_END;
                  phase_d = PH_IDLE;
                end else if (lit_new == '0) begin
                  res.block_end = 1'b1;
                  phase_d = PH_IDLE;
                end else begin
                  phase_d = PH_LIT;
                end
              end else begin
                phase_d = (lit_new == '0) ? PH_OFFLO : PH_LIT;
              end
            end
          end
          PH_LIT: begin
            we = 1'b1;
            prod_d = prod_q + 1'b1;
            res.out_byte = b;
            res.out_valid = 1'b1;
            lit_d = lit_q - 1'b1;
            if (lit_d == '0) begin
              if (prod_d == tgt_q) begin
                res.block_end = 1'b1;
                phase_d = PH_IDLE;
              end else begin
                phase_d = PH_OFFLO;
              end
            end
          end
          PH_OFFLO: begin
            off_d = {8'd0, b};
            phase_d = PH_OFFHI;
          end
          default: begin
            if (phase_q == PH_OFFHI) begin
              off_d = {b, off_q[7:0]};
              mat_new = LenW'(tlow_q);
            end else begin
              mat_new = ((LenW+1)'(mat_q) + (LenW+1)'(b) > (LenW+1)'(LenCap)) ?
                        LenCap : mat_q + LenW'(b);
            end
            mat_d = mat_new;
            if (phase_q == PH_OFFHI && (off_d == 16'd0 ||
                (LenW+2)'(off_d) > (LenW+2)'(prod_q) || (LenW+2)'(off_d) > HistD)) begin
              res.block_end = 1'b1;
              res.status = lz4bd_pkg::ST_BAD_OFF;
              phase_d = PH_IDLE;
            end else if ((phase_q == PH_OFFHI && tlow_q == 4'hF) ||
                         (phase_q == PH_MATEXT && b == 8'hFF)) begin
              phase_d = PH_MATEXT;
            end else begin
              mat4 = (mat_new > LenCap - LenW'(4)) ? LenCap : mat_new + LenW'(4);
              mat_d = mat4;
              tot_mat = (LenW+2)'(prod_q) + (LenW+2)'(mat4) + (LenW+2)'(5);
              if (tot_mat > (LenW+2)'(tgt_q)) begin
                res.block_end = 1'b1;
                res.status = lz4bd_pkg::ST_MATCH_END;
                phase_d = PH_IDLE;
              end else begin
                phase_d = PH_DRAIN;
              end
            end
          end
        endcase
      end else if (op == lz4bd_pkg::OP_DRAIN && phase_q == PH_DRAIN) begin
        we = 1'b1;
        wdata = rdata;
        prod_d = prod_q + 1'b1;
        res.out_byte = rdata;
        res.out_valid = 1'b1;
        mat_d = mat_q - 1'b1;
        if (mat_d == '0) phase_d = PH_TOKEN;
      end else begin
        res.block_end = 1'b1;
        res.status = lz4bd_pkg::ST_UNEXPECT;
        phase_d = PH_IDLE;
      end
      res.want_byte = (phase_d != PH_IDLE && phase_d != PH_DRAIN);
      res.bytes_read = cons_d;
    end
  end

  // Read ahead for the next drain word, from the next output count and offset.
  assign raddr = prod_d[AddrW-1:0] - off_d[AddrW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      prod_q  <= '0;
      tgt_q   <= '0;
      lit_q   <= '0;
      mat_q   <= '0;
      off_q   <= '0;
      tlow_q  <= '0;
      cons_q  <= '0;
      cnt_q   <= '0;
      rd_q    <= 1'b0;
      fwd_q   <= 1'b0;
    end else begin
      phase_q <= phase_d;
      prod_q  <= prod_d;
      tgt_q   <= tgt_d;
      lit_q   <= lit_d;
      mat_q   <= mat_d;
      off_q   <= off_d;
      tlow_q  <= tlow_d;
      cons_q  <= cons_d;
      fwd_q   <= we && (raddr == prod_q[AddrW-1:0]);
      if (pop) rd_q <= ~rd_q;
      cnt_q <= cnt_q + {1'b0, acc} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk_i) begin
    fwd_byte_q <= wdata;
    if (acc) slot_q[rd_q ^ cnt_q[0]] <= res;
  end

  // Result slots never overflow.
  assert property (@(posedge clk_i) disable iff (!rst_ni) cnt_q != 2'd3)
    else $error("result slot count overflow");
  // A drain word accepted in the drain phase always grows the output count by one.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc && op == lz4bd_pkg::OP_DRAIN && phase_q == PH_DRAIN |=> prod_q == $past(prod_q) + 1'b1)
    else $error("drain did not advance output count");
  // A result that sends the decoder to the idle phase never wants a byte.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc && phase_d == PH_IDLE |-> !res.want_byte)
    else $error("idle result wants a byte");

endmodule

### rtl/lz4bd_history.sv
// lz4bd_history: history store of decoded bytes, one write and one read port.
// Read data is registered. Depends on nothing.
`timescale 1ns / 1ps
module lz4bd_history #(
  parameter int unsigned AddrW = 16
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [7:0]       wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [7:0]       rdata_o
);

  logic [7:0] mem_q [2**AddrW];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule
